/* src/brld_pkg.sv */
// Shared types and constants for the block run-length decoder.
// No dependencies; the configuration interface and every module file import this package.
`default_nettype none

package brld_pkg;

  localparam int MAX_BLOCK_BYTES = 8;
  localparam int OUT_WORD_BYTES  = 16;
  localparam int LENGTH_BITS     = 24;

  localparam int BS_BITS   = 4;
  localparam int CAP_BITS  = 24;
  localparam int VB_BITS   = 5;
  localparam int CNT_BITS  = 7;
  localparam int LIT_BITS  = 10;
  localparam int IDX_BITS  = 3;
  localparam int WORD_BITS = 64;
  localparam int CFG_DATA_BITS = 24;

  localparam logic [7:0] OP_COUNT_MASK   = 8'h7F;
  localparam logic [7:0] OP_LITERAL_FLAG = 8'h80;

  typedef enum logic [0:0] {
    REG_BLOCK_SIZE      = 1'b0,
    REG_OUTPUT_CAPACITY = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_OPCODE,
    ST_LITERAL,
    ST_BLOCK,
    ST_EXPAND,
    ST_DISCARD
  } state_t;

  typedef struct packed {
    logic lit_load;
    logic rep_load;
    logic lit_emit;
    logic blk_store;
    logic exp_emit;
    logic lone_emit;
    logic err_emit;
    logic set_end;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic ovf;
    logic op_literal;
    logic lit_nonzero;
    logic lit_final;
    logic blk_done;
    logic copies_zero;
    logic exp_last;
  } sts_t;

  typedef struct packed {
    logic [WORD_BITS-1:0]   data_low;
    logic [WORD_BITS-1:0]   data_high;
    logic [VB_BITS-1:0]     valid_bytes;
    logic                   stream_end;
    logic                   overflow_error;
    logic [LENGTH_BITS-1:0] total_length;
  } res_t;

endpackage

`default_nettype wire

/* src/brld_in_if.sv */
// Input channel of the block run-length decoder: one encoded byte per item.
// Depends on nothing.
`default_nettype none

interface brld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       stream_last;

  modport source (output valid, output code_byte, output stream_last, input ready);
  modport sink   (input valid, input code_byte, input stream_last, output ready);
endinterface

`default_nettype wire

/* src/brld_out_if.sv */
// Result channel of the block run-length decoder.
// Depends on nothing.
`default_nettype none

interface brld_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_low;
  logic [63:0] data_high;
  logic [4:0]  valid_bytes;
  logic        stream_end;
  logic        overflow_error;
  logic [23:0] total_length;

  modport source (output valid, output data_low, output data_high, output valid_bytes,
                  output stream_end, output overflow_error, output total_length,
                  input ready);
  modport sink   (input valid, input data_low, input data_high, input valid_bytes,
                  input stream_end, input overflow_error, input total_length,
                  output ready);
endinterface

`default_nettype wire

/* src/brld_cfg_if.sv */
// Configuration write channel of the block run-length decoder.
// Depends on brld_pkg for the register index type.
`default_nettype none

interface brld_cfg_if;
  logic                     valid;
  logic                     ready;
  brld_pkg::cfg_idx_t       reg_index;
  logic [23:0]              wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

/* src/brld_cfg.sv */
// Configuration registers and effective block size of the decoder.
// Depends on brld_pkg.
`default_nettype none

module brld_cfg
  import brld_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  cfg_idx_t             wr_index,
  input  logic [CFG_DATA_BITS-1:0] wr_data,
  output logic [BS_BITS-1:0]   bs_eff,
  output logic [CAP_BITS-1:0]  capacity
);

  logic [BS_BITS-1:0]  bs_r;
  logic [CAP_BITS-1:0] cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r  <= BS_BITS'(1);
      cap_r <= '1;
    end else if (wr_en) begin
      case (wr_index)
        REG_BLOCK_SIZE:      bs_r  <= wr_data[BS_BITS-1:0];
        REG_OUTPUT_CAPACITY: cap_r <= wr_data[CAP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Zero behaves as one byte, oversize values as the largest block.
  always_comb begin
    if (bs_r == '0) begin
      bs_eff = BS_BITS'(1);
    end else if (bs_r > BS_BITS'(MAX_BLOCK_BYTES)) begin
      bs_eff = BS_BITS'(MAX_BLOCK_BYTES);
    end else begin
      bs_eff = bs_r;
    end
  end

  assign capacity = cap_r;

endmodule

`default_nettype wire

/* src/brld_ctrl.sv */
// Parse controller of the decoder: state machine that sequences the datapath.
// Depends on brld_pkg for the state, command and status types.
`default_nettype none

module brld_ctrl
  import brld_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_last,
  input  sts_t sts,
  output logic in_ready,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   last_pend_r, last_pend_nxt;
  logic   accept;

  assign in_ready = (state_r != ST_EXPAND) && sts.out_free;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_OPCODE;
      last_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_pend_r <= last_pend_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    last_pend_nxt = last_pend_r;
    case (state_r)
      ST_OPCODE: begin
        if (accept) begin
          if (sts.ovf) begin
            state_nxt = in_last ? ST_OPCODE : ST_DISCARD;
          end else if (in_last) begin
            state_nxt = ST_OPCODE;
          end else if (sts.op_literal) begin
            state_nxt = sts.lit_nonzero ? ST_LITERAL : ST_OPCODE;
          end else begin
            state_nxt = ST_BLOCK;
          end
        end
      end
      ST_LITERAL: begin
        if (accept && (in_last || sts.lit_final)) begin
          state_nxt = ST_OPCODE;
        end
      end
      ST_BLOCK: begin
        if (accept) begin
          if (sts.blk_done) begin
            if (sts.copies_zero) begin
              state_nxt = ST_OPCODE;
            end else begin
              state_nxt     = ST_EXPAND;
              last_pend_nxt = in_last;
            end
          end else if (in_last) begin
            state_nxt = ST_OPCODE;
          end
        end
      end
      ST_EXPAND: begin
        if (sts.out_free && sts.exp_last) begin
          state_nxt = ST_OPCODE;
        end
      end
      ST_DISCARD: begin
        if (accept && in_last) begin
          state_nxt = ST_OPCODE;
        end
      end
      default: state_nxt = ST_OPCODE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_OPCODE: begin
        if (accept) begin
          if (sts.ovf) begin
            if (in_last) begin
              cmd.err_emit = 1'b1;
              cmd.clear    = 1'b1;
            end
          end else if (in_last) begin
            cmd.lone_emit = 1'b1;
            cmd.clear     = 1'b1;
          end else if (sts.op_literal) begin
            cmd.lit_load = 1'b1;
          end else begin
            cmd.rep_load = 1'b1;
          end
        end
      end
      ST_LITERAL: begin
        if (accept) begin
          cmd.lit_emit = 1'b1;
          if (in_last) begin
            cmd.set_end = 1'b1;
            cmd.clear   = 1'b1;
          end
        end
      end
      ST_BLOCK: begin
        if (accept) begin
          cmd.blk_store = 1'b1;
          if (in_last && (!sts.blk_done || sts.copies_zero)) begin
            cmd.lone_emit = 1'b1;
            cmd.clear     = 1'b1;
          end
        end
      end
      ST_EXPAND: begin
        if (sts.out_free) begin
          cmd.exp_emit = 1'b1;
          if (sts.exp_last && last_pend_r) begin
            cmd.set_end = 1'b1;
            cmd.clear   = 1'b1;
          end
        end
      end
      ST_DISCARD: begin
        if (accept && in_last) begin
          cmd.err_emit = 1'b1;
          cmd.clear    = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* src/brld_datapath.sv */
// Datapath of the decoder: run counters, block buffer, length tracking,
// repeat-word builder and the output register. Depends on brld_pkg.
`default_nettype none

module brld_datapath
  import brld_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          code_byte,
  input  logic [BS_BITS-1:0]  bs,
  input  logic [CAP_BITS-1:0] capacity,
  input  cmd_t                cmd,
  input  logic                out_ready,
  output sts_t                sts,
  output logic                out_valid,
  output res_t                out_res
);

  logic [LIT_BITS-1:0]    lit_left_r, lit_left_nxt;
  logic [CNT_BITS-1:0]    copies_r, copies_nxt;
  logic [WORD_BITS-1:0]   blk_r;
  logic [IDX_BITS-1:0]    idx_r, idx_nxt;
  logic [LENGTH_BITS-1:0] prod_r, prod_nxt;
  logic                   out_valid_r;
  res_t                   out_r, res;

  logic [7:0]             masked;
  logic [CNT_BITS-1:0]    cnt;
  logic [10:0]            bytes_full;
  logic [LENGTH_BITS:0]   len_sum;
  logic [IDX_BITS-1:0]    idx_inc;
  logic [VB_BITS-1:0]     per;
  logic [VB_BITS-1:0]     copies_now;
  logic [8:0]             nb_full;
  logic [VB_BITS-1:0]     nb;
  logic [7:0]             pick;
  logic [2*WORD_BITS-1:0] rep_word;

  // Opcode decode and the capacity check for the coming run.
  assign masked     = code_byte & OP_COUNT_MASK;
  assign cnt        = masked[CNT_BITS-1:0];
  assign bytes_full = 11'(cnt) * 11'(bs);
  assign len_sum    = (LENGTH_BITS+1)'(prod_r) + (LENGTH_BITS+1)'(bytes_full);

  assign idx_inc = idx_r + IDX_BITS'(1);

  // Whole block copies that fit in one output word.
  always_comb begin
    case (bs)
      4'd2:    per = VB_BITS'(OUT_WORD_BYTES / 2);
      4'd3:    per = VB_BITS'(OUT_WORD_BYTES / 3);
      4'd4:    per = VB_BITS'(OUT_WORD_BYTES / 4);
      4'd5:    per = VB_BITS'(OUT_WORD_BYTES / 5);
      4'd6:    per = VB_BITS'(OUT_WORD_BYTES / 6);
      4'd7:    per = VB_BITS'(OUT_WORD_BYTES / 7);
      4'd8:    per = VB_BITS'(OUT_WORD_BYTES / 8);
      default: per = VB_BITS'(OUT_WORD_BYTES);
    endcase
  end

  assign sts.exp_last = copies_r <= CNT_BITS'(per);
  assign copies_now   = sts.exp_last ? copies_r[VB_BITS-1:0] : per;
  assign nb_full      = 9'(copies_now) * 9'(bs);
  assign nb           = nb_full[VB_BITS-1:0];

  // Each output byte takes a fixed block byte for a given block size.
  always_comb begin
    rep_word = '0;
    pick     = '0;
    for (int k = 0; k < OUT_WORD_BYTES; k++) begin
      case (bs)
        4'd2:    pick = blk_r[(k % 2)*8 +: 8];
        4'd3:    pick = blk_r[(k % 3)*8 +: 8];
        4'd4:    pick = blk_r[(k % 4)*8 +: 8];
        4'd5:    pick = blk_r[(k % 5)*8 +: 8];
        4'd6:    pick = blk_r[(k % 6)*8 +: 8];
        4'd7:    pick = blk_r[(k % 7)*8 +: 8];
        4'd8:    pick = blk_r[(k % 8)*8 +: 8];
        default: pick = blk_r[7:0];
      endcase
      if (VB_BITS'(k) < nb) begin
        rep_word[k*8 +: 8] = pick;
      end
    end
  end

  assign sts.out_free    = !out_valid_r || out_ready;
  assign sts.ovf         = len_sum > (LENGTH_BITS+1)'(capacity);
  assign sts.op_literal  = (code_byte & OP_LITERAL_FLAG) != 8'h00;
  assign sts.lit_nonzero = bytes_full != '0;
  assign sts.lit_final   = lit_left_r <= LIT_BITS'(1);
  assign sts.blk_done    = (idx_inc == '0) || ({1'b0, idx_inc} >= bs);
  assign sts.copies_zero = copies_r == '0;

  // Result selection for whichever emit command is active.
  always_comb begin
    res = '0;
    if (cmd.lit_emit) begin
      res.data_low     = WORD_BITS'(code_byte);
      res.valid_bytes  = VB_BITS'(1);
      res.total_length = prod_r + LENGTH_BITS'(1);
    end else if (cmd.exp_emit) begin
      res.data_low     = rep_word[WORD_BITS-1:0];
      res.data_high    = rep_word[2*WORD_BITS-1:WORD_BITS];
      res.valid_bytes  = nb;
      res.total_length = prod_r + LENGTH_BITS'(nb);
    end else if (cmd.lone_emit) begin
      res.stream_end   = 1'b1;
      res.total_length = prod_r;
    end else if (cmd.err_emit) begin
      res.stream_end     = 1'b1;
      res.overflow_error = 1'b1;
    end
    if (cmd.set_end) begin
      res.stream_end = 1'b1;
    end
  end

  always_comb begin
    lit_left_nxt = lit_left_r;
    copies_nxt   = copies_r;
    idx_nxt      = idx_r;
    prod_nxt     = prod_r;
    if (cmd.lit_load) begin
      lit_left_nxt = bytes_full[LIT_BITS-1:0];
    end
    if (cmd.rep_load) begin
      copies_nxt = cnt;
      idx_nxt    = '0;
    end
    if (cmd.lit_emit) begin
      prod_nxt = prod_r + LENGTH_BITS'(1);
      if (lit_left_r != '0) begin
        lit_left_nxt = lit_left_r - LIT_BITS'(1);
      end
    end
    if (cmd.blk_store) begin
      idx_nxt = idx_inc;
    end
    if (cmd.exp_emit) begin
      prod_nxt   = prod_r + LENGTH_BITS'(nb);
      copies_nxt = copies_r - CNT_BITS'(copies_now);
    end
    if (cmd.clear) begin
      prod_nxt = '0;
      idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lit_left_r  <= '0;
      copies_r    <= '0;
      idx_r       <= '0;
      prod_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      lit_left_r <= lit_left_nxt;
      copies_r   <= copies_nxt;
      idx_r      <= idx_nxt;
      prod_r     <= prod_nxt;
      if (cmd.lit_emit || cmd.exp_emit || cmd.lone_emit || cmd.err_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.blk_store) begin
      blk_r[idx_r*8 +: 8] <= code_byte;
    end
    if (cmd.lit_emit || cmd.exp_emit || cmd.lone_emit || cmd.err_emit) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

`default_nettype wire

/* src/block_rle_decompressor_core.sv */
// Top level of the block run-length decoder: configuration registers,
// parse controller and datapath. Depends on brld_pkg and the three channel interfaces.
//
//   Channel  Direction  Carries                                  Handshake
//   in_ch    sink       code_byte, stream_last                   valid/ready
//   out_ch   source     data_low/high, valid_bytes, stream_end,  valid/ready
//                       overflow_error, total_length
//   cfg_ch   sink       reg_index, wr_data                       valid/ready (always ready)
//
// Opcodes, literal bytes and block bytes are each taken on acceptance, so the input runs
// at one item per cycle while the single output register is free and no block expands.
// A completed repeat block holds the input while it is expanded into
// ceil(count / (16 / block_size)) packed results, one per cycle while out_ch takes them.
// Reset is synchronous and active low; it clears the parse state and loads
// block_size = 1 and output_capacity = 0xFFFFFF. While the output register holds
// a result that out_ch has not taken, the input is held for every item, even
// for one that would make no result.
`default_nettype none

module block_rle_decompressor_core
  import brld_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  brld_in_if.sink    in_ch,
  brld_out_if.source out_ch,
  brld_cfg_if.sink   cfg_ch
);

  logic [BS_BITS-1:0]  bs_eff;
  logic [CAP_BITS-1:0] capacity;
  cmd_t                cmd;
  sts_t                sts;
  res_t                out_res;
  logic                out_valid;

  // Configuration writes are always taken; the sender must issue them only while
  // no item is in flight, which the block itself does not enforce.
  assign cfg_ch.ready = 1'b1;

  brld_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.reg_index),
    .wr_data  (cfg_ch.wr_data),
    .bs_eff   (bs_eff),
    .capacity (capacity)
  );

  // The controller decides what each accepted byte means; it sees the
  // datapath only through the status struct.
  brld_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.stream_last),
    .sts      (sts),
    .in_ready (in_ch.ready),
    .cmd      (cmd)
  );

  brld_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .code_byte (in_ch.code_byte),
    .bs        (bs_eff),
    .capacity  (capacity),
    .cmd       (cmd),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_ch.valid          = out_valid;
  assign out_ch.data_low       = out_res.data_low;
  assign out_ch.data_high      = out_res.data_high;
  assign out_ch.valid_bytes    = out_res.valid_bytes;
  assign out_ch.stream_end     = out_res.stream_end;
  assign out_ch.overflow_error = out_res.overflow_error;
  assign out_ch.total_length   = out_res.total_length;

  // An overflow result is always a bare end marker with a zero length.
  a_err_result : assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.overflow_error) |->
      (out_ch.stream_end && out_ch.total_length == '0 && out_ch.valid_bytes == '0))
    else $error("overflow result carries data or length");

  // A result never packs more bytes than the output word holds.
  a_word_size : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.valid_bytes <= VB_BITS'(OUT_WORD_BYTES)))
    else $error("result claims more bytes than one word");

  // At most one result source is selected in a cycle.
  a_one_emit : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.lit_emit, cmd.exp_emit, cmd.lone_emit, cmd.err_emit}))
    else $error("two result sources selected together");

  // A result is only loaded when the output register is free or being drained.
  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.lit_emit || cmd.exp_emit || cmd.lone_emit || cmd.err_emit) |->
      (!out_ch.valid || out_ch.ready))
    else $error("result overwrote a pending output");

endmodule

`default_nettype wire
